@@ rtl/core/utf8d_pkg.sv @@
// Package for the UTF-8 stream decoder: widths, byte class masks and codes.
// No dependencies; used by the channel interfaces and the decoder core.
package utf8d_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CpW        = 21;
  localparam int unsigned MaxResults = 4;
  // Result counter holds 0..MaxResults
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned SeqW       = 3;
  localparam int unsigned TakenW     = 2;

  // Byte classes: mask and code pairs
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;
  localparam logic [ByteW-1:0] AsciiMask = 8'h80;
  localparam logic [ByteW-1:0] AsciiCode = 8'h00;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;

  // Payload masks per byte kind
  localparam logic [ByteW-1:0] ContPayload  = 8'h3F;
  localparam logic [ByteW-1:0] Lead2Payload = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Payload = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Payload = 8'h07;

  // Sequence lengths
  localparam logic [SeqW-1:0] SeqNone = 3'd0;
  localparam logic [SeqW-1:0] SeqLen2 = 3'd2;
  localparam logic [SeqW-1:0] SeqLen3 = 3'd3;
  localparam logic [SeqW-1:0] SeqLen4 = 3'd4;

  // Results of one byte: cnt entries, all bad zeros except possibly the
  // final one, which carries value when good is set.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            good;
    logic [CpW-1:0]  value;
  } burst_t;

endpackage

@@ rtl/core/utf8d_if.sv @@
// Valid/ready channel interfaces for the UTF-8 stream decoder.
// Depends on utf8d_pkg for the payload widths.
interface utf8d_byte_if
  import utf8d_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface utf8d_cp_if
  import utf8d_pkg::*;
  ();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           bad_byte;
  logic           run_last;
  logic           stream_done;

  modport source (output valid, code_point, bad_byte, run_last, stream_done, input ready);
  modport sink   (input valid, code_point, bad_byte, run_last, stream_done, output ready);
endinterface

@@ rtl/core/utf8_stream_decoder_core.sv @@
// UTF-8 stream decoder core: bytes in, 21-bit code points out.
// Depends on utf8d_pkg and the channel interfaces in utf8d_if.sv.
//
// Usage:
//   byte_i takes one raw byte per transfer with stream_end marking the last
//   byte of a stream. cp_o gives one code point per transfer; bad_byte marks
//   zero results standing for invalid or orphaned bytes, run_last marks the
//   last result of a byte and stream_done the last result of a stream.
//   A byte goes into an input register and is decoded from there into a
//   result register, from which its results show on cp_o. Throughput is
//   one byte per cycle while each byte gives at most one result and the
//   receiver takes every result; a byte that gives N results (error
//   flushes, N up to 4) holds the result register until all N have
//   drained, one result per transfer. The input register lets one byte be
//   taken while a result waits on a stalled receiver; then byte_i.ready
//   stays low until the last result in the result register transfers.
//   Reset empties both registers and closes any open sequence. A byte with
//   stream_end set clears the sequence state so the next byte starts anew.
module utf8_stream_decoder_core
  import utf8d_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8d_byte_if.sink    byte_i,
  utf8d_cp_if.source    cp_o
);

  // Input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_end_q;

  // Sequence state
  logic [SeqW-1:0]   seq_q, seq_d;
  logic [TakenW-1:0] taken_q, taken_d;
  logic [CpW-1:0]    pv_q, pv_d;

  // Result register
  logic [CntW-1:0] rem_q;
  logic            good_q;
  logic [CpW-1:0]  val_q;
  logic            done_q;

  burst_t burst;
  logic   advance;
  logic   slot_free;

  // Result slot frees when empty or its final result transfers now
  assign slot_free = (rem_q == '0) ||
                     ((rem_q == CntW'(1)) && cp_o.ready);
  assign advance   = in_vld_q && slot_free;
  assign byte_i.ready = !in_vld_q || advance;

  // Decode one byte against the open sequence
  always_comb begin
    logic [ByteW-1:0]  b;
    logic              is_cont;
    logic              open_seq;
    logic [TakenW-1:0] taken_nx;
    logic              complete;
    logic [CntW-1:0]   n;
    b        = in_byte_q;
    is_cont  = (b & ContMask) == ContCode;
    open_seq = seq_q != SeqNone;
    taken_nx = taken_q + TakenW'(1);
    complete = ({1'b0, taken_nx} + SeqW'(1)) >= seq_q;
    n        = '0;
    seq_d    = seq_q;
    taken_d  = taken_q;
    pv_d     = pv_q;
    burst.good  = 1'b0;
    burst.value = '0;

    if (open_seq && is_cont) begin
      // Continuation: gather six more payload bits
      pv_d    = {pv_q[CpW-7:0], b[5:0] & ContPayload[5:0]};
      taken_d = taken_nx;
      if (complete) begin
        n           = CntW'(1);
        burst.good  = 1'b1;
        burst.value = pv_d;
        seq_d       = SeqNone;
        taken_d     = '0;
        pv_d        = '0;
      end
    end else begin
      // Broken sequence: one zero for the lead and each continuation
      if (open_seq) begin
        n = CntW'(1) + CntW'(taken_q);
      end
      seq_d   = SeqNone;
      taken_d = '0;
      pv_d    = '0;
      if ((b & AsciiMask) == AsciiCode) begin
        n           = n + CntW'(1);
        burst.good  = 1'b1;
        burst.value = CpW'(b);
      end else if ((b & Lead2Mask) == Lead2Code) begin
        seq_d = SeqLen2;
        pv_d  = CpW'(b & Lead2Payload);
      end else if ((b & Lead3Mask) == Lead3Code) begin
        seq_d = SeqLen3;
        pv_d  = CpW'(b & Lead3Payload);
      end else if ((b & Lead4Mask) == Lead4Code) begin
        seq_d = SeqLen4;
        pv_d  = CpW'(b & Lead4Payload);
      end else begin
        n = n + CntW'(1);
      end
    end

    // Stream end: flush anything still open
    if (in_end_q) begin
      if (seq_d != SeqNone) begin
        n          = n + CntW'(1) + CntW'(taken_d);
        burst.good = 1'b0;
      end
      seq_d   = SeqNone;
      taken_d = '0;
      pv_d    = '0;
    end
    burst.cnt = n;
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
      in_end_q  <= byte_i.stream_end;
    end
  end

  // Sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SeqNone;
      taken_q <= '0;
      pv_q    <= '0;
    end else if (advance) begin
      seq_q   <= seq_d;
      taken_q <= taken_d;
      pv_q    <= pv_d;
    end
  end

  // Result register: counts down one result per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (advance) begin
      rem_q <= burst.cnt;
    end else if (cp_o.valid && cp_o.ready) begin
      rem_q <= rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      good_q <= burst.good;
      val_q  <= burst.value;
      done_q <= in_end_q;
    end
  end

  // Output side
  assign cp_o.valid       = rem_q != '0;
  assign cp_o.run_last    = rem_q == CntW'(1);
  assign cp_o.bad_byte    = !(cp_o.run_last && good_q);
  assign cp_o.code_point  = (cp_o.run_last && good_q) ? val_q : '0;
  assign cp_o.stream_done = cp_o.run_last && done_q;

  // Checks
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= CntW'(MaxResults))
    else $error("result count above limit");

  a_seq_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == SeqNone || seq_q == SeqLen2 || seq_q == SeqLen3 || seq_q == SeqLen4)
    else $error("illegal sequence length");

  a_taken_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SeqNone) |-> (taken_q == '0))
    else $error("continuation count without open sequence");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_end_q) |=> (seq_q == SeqNone && rem_q != '0))
    else $error("stream end left state open or gave no result");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cp_o.valid && !cp_o.ready) |=> (rem_q == $past(rem_q)))
    else $error("result count moved while receiver stalled");

endmodule

@@ dv/tb_utf8_stream_decoder_core.sv @@
`timescale 1ns / 1ps
// Testbench for utf8_stream_decoder_core: directed byte table, then random UTF-8 runs
// checked against a cycle-free decode predictor. Needs utf8d_pkg, utf8d_if.sv and the core.
module tb_utf8_stream_decoder_core;
  import utf8d_pkg::*;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           bad_byte;
    logic           run_last;
    logic           stream_done;
  } cp_res_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             stream_end;
    logic             typed;
    cp_res_t          res;
  } byte_row_t;

  localparam int PhaseItems = 70;
  localparam int HoldCycles = 80;

  logic clk_i;
  logic rst_ni;

  utf8d_byte_if byte_if ();
  utf8d_cp_if   cp_if ();

  utf8_stream_decoder_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .cp_o   (cp_if)
  );

  // Predictor state: open sequence length, continuations seen, gathered payload
  logic [SeqW-1:0]   open_len;
  logic [TakenW-1:0] cont_seen;
  logic [CpW-1:0]    acc_value;

  // Results of the byte being decoded
  cp_res_t           byte_res [MaxResults];
  int                byte_res_n;

  cp_res_t           cp_expected_q [$];
  int                fails = 0;
  int                src_idle_pct = 0;
  int                sink_stall_pct = 0;
  int                hold_cnt = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic byte_row_t row(input logic [ByteW-1:0] b, input logic e,
                                    input logic typed, input logic [CpW-1:0] cp,
                                    input logic bad);
    byte_row_t r;
    r.data_byte = b;
    r.stream_end = e;
    r.typed = typed;
    r.res = '{code_point: cp, bad_byte: bad, run_last: 1'b1, stream_done: e};
    return r;
  endfunction

  function automatic void add_res(input logic [CpW-1:0] cp, input logic bad);
    if (byte_res_n < MaxResults) begin
      byte_res[byte_res_n] = '{code_point: cp, bad_byte: bad, run_last: 1'b0,
                               stream_done: 1'b0};
      byte_res_n++;
    end
  endfunction

  function automatic void close_seq();
    open_len = SeqNone;
    cont_seen = '0;
    acc_value = '0;
  endfunction

  // A zero result for the lead and one per collected continuation
  function automatic void flush_seq();
    for (int k = 0; k <= int'(cont_seen); k++) add_res('0, 1'b1);
    close_seq();
  endfunction

  function automatic void start_fresh(input logic [ByteW-1:0] b);
    if ((b & AsciiMask) == AsciiCode) begin
      add_res(CpW'(b), 1'b0);
    end else if ((b & Lead2Mask) == Lead2Code) begin
      open_len = SeqLen2;
      cont_seen = '0;
      acc_value = CpW'(b & Lead2Payload);
    end else if ((b & Lead3Mask) == Lead3Code) begin
      open_len = SeqLen3;
      cont_seen = '0;
      acc_value = CpW'(b & Lead3Payload);
    end else if ((b & Lead4Mask) == Lead4Code) begin
      open_len = SeqLen4;
      cont_seen = '0;
      acc_value = CpW'(b & Lead4Payload);
    end else begin
      add_res('0, 1'b1);
    end
  endfunction

  // Decode one byte into byte_res / byte_res_n and advance the state
  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic e);
    byte_res_n = 0;
    if (open_len != SeqNone) begin
      if ((b & ContMask) == ContCode) begin
        acc_value = {acc_value[CpW-7:0], b[5:0]};
        cont_seen++;
        if (int'(cont_seen) + 1 >= int'(open_len)) begin
          add_res(acc_value, 1'b0);
          close_seq();
        end
      end else begin
        flush_seq();
        start_fresh(b);
      end
    end else begin
      start_fresh(b);
    end
    // Stream end closes any open sequence
    if (e) begin
      if (open_len != SeqNone) flush_seq();
      close_seq();
    end
    if (byte_res_n > 0) begin
      byte_res[byte_res_n-1].run_last = 1'b1;
      byte_res[byte_res_n-1].stream_done = e;
    end
  endfunction

  // Offer one byte; called and returning at a falling edge, valid left high
  task automatic send_byte(input logic [ByteW-1:0] b, input logic e,
                           input logic typed, input cp_res_t typed_res);
    if ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.stream_end <= e;
    do @(posedge clk_i); while (!byte_if.ready);
    // Transfer taken at this edge
    decode_byte(b, e);
    if (typed) begin
      cp_expected_q.push_back(typed_res);
    end else begin
      for (int k = 0; k < byte_res_n; k++) cp_expected_q.push_back(byte_res[k]);
    end
    @(negedge clk_i);
  endtask

  // Mostly well-formed sequences, some cut short, stray continuations and noise
  task automatic send_random_run(inout int sent);
    logic [ByteW-1:0] seq [$];
    logic [CpW-1:0]   v;
    int               kind;
    int               len;
    int               keep;
    kind = $urandom_range(99);
    len = $urandom_range(1, 4);
    v = CpW'($urandom);
    if (kind < 75) begin
      case (len)
        1: seq = '{{1'b0, v[6:0]}};
        2: seq = '{{3'b110, v[10:6]}, {2'b10, v[5:0]}};
        3: seq = '{{4'b1110, v[15:12]}, {2'b10, v[11:6]}, {2'b10, v[5:0]}};
        default: seq = '{{5'b11110, v[20:18]}, {2'b10, v[17:12]}, {2'b10, v[11:6]},
                         {2'b10, v[5:0]}};
      endcase
      // Broken sequence: drop the tail; the next run breaks it unless it starts with a continuation
      if (kind >= 60 && len > 1) begin
        keep = $urandom_range(1, len - 1);
        while (seq.size() > keep) void'(seq.pop_back());
      end
    end else if (kind < 88) begin
      seq = '{{2'b10, v[5:0]}};
    end else begin
      seq = '{v[7:0]};
    end
    foreach (seq[i]) begin
      send_byte(seq[i], ($urandom_range(15) == 0), 1'b0, '0);
      sent++;
    end
  endtask

  // Sender rests until every expected result has come
  task automatic drain();
    byte_if.valid <= 1'b0;
    while (cp_expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Receiver: random stalls, or a counted hold-off
  initial begin
    cp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        cp_if.ready <= 1'b0;
        hold_cnt--;
      end else begin
        cp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    cp_res_t want;
    if (rst_ni && cp_if.valid && cp_if.ready) begin
      if (cp_expected_q.size() == 0) begin
        $error("result with nothing expected: code_point %h bad_byte %b",
               cp_if.code_point, cp_if.bad_byte);
        fails++;
      end else begin
        want = cp_expected_q.pop_front();
        if (cp_if.code_point !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, cp_if.code_point);
          fails++;
        end
        if (cp_if.bad_byte !== want.bad_byte) begin
          $error("bad_byte: expected %b, got %b", want.bad_byte, cp_if.bad_byte);
          fails++;
        end
        if (cp_if.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, cp_if.run_last);
          fails++;
        end
        if (cp_if.stream_done !== want.stream_done) begin
          $error("stream_done: expected %b, got %b", want.stream_done,
                 cp_if.stream_done);
          fails++;
        end
      end
    end
  end

  initial begin
    byte_row_t bytes_tbl [$];
    int        src_tbl [4];
    int        sink_tbl [4];
    int        sent;

    src_tbl = '{0, 82, 0, 20};
    sink_tbl = '{0, 0, 82, 20};
    rst_ni = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.data_byte = '0;
    byte_if.stream_end = 1'b0;
    close_seq();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed bytes; typed rows carry their single result
    bytes_tbl = '{
      row(8'h00, 1'b0, 1'b1, 21'h0, 1'b0),      // null decodes as zero, not bad
      row(8'h7F, 1'b0, 1'b1, 21'h7F, 1'b0),
      row(8'h80, 1'b0, 1'b1, 21'h0, 1'b1),      // stray continuations
      row(8'hBF, 1'b0, 1'b1, 21'h0, 1'b1),
      row(8'hF8, 1'b0, 1'b1, 21'h0, 1'b1),      // never valid in UTF-8
      row(8'hFF, 1'b0, 1'b1, 21'h0, 1'b1),
      row(8'hC2, 1'b0, 1'b0, '0, 1'b0),         // two-byte
      row(8'hA9, 1'b0, 1'b0, '0, 1'b0),
      row(8'hE2, 1'b0, 1'b0, '0, 1'b0),         // three-byte
      row(8'h82, 1'b0, 1'b0, '0, 1'b0),
      row(8'hAC, 1'b0, 1'b0, '0, 1'b0),
      row(8'hF4, 1'b0, 1'b0, '0, 1'b0),         // top of Unicode
      row(8'h8F, 1'b0, 1'b0, '0, 1'b0),
      row(8'hBF, 1'b0, 1'b0, '0, 1'b0),
      row(8'hBF, 1'b0, 1'b0, '0, 1'b0),
      row(8'hF7, 1'b0, 1'b0, '0, 1'b0),         // all-ones 21-bit value
      row(8'hBF, 1'b0, 1'b0, '0, 1'b0),
      row(8'hBF, 1'b0, 1'b0, '0, 1'b0),
      row(8'hBF, 1'b0, 1'b0, '0, 1'b0),
      row(8'hF0, 1'b0, 1'b0, '0, 1'b0),         // broken four-byte: three zeros + 'A'
      row(8'h90, 1'b0, 1'b0, '0, 1'b0),
      row(8'h80, 1'b0, 1'b0, '0, 1'b0),
      row(8'h41, 1'b0, 1'b0, '0, 1'b0),
      row(8'hE0, 1'b1, 1'b1, 21'h0, 1'b1),      // lead open at stream end
      row(8'hDF, 1'b0, 1'b0, '0, 1'b0),         // broken by the last byte
      row(8'h41, 1'b1, 1'b0, '0, 1'b0)
    };
    foreach (bytes_tbl[i])
      send_byte(bytes_tbl[i].data_byte, bytes_tbl[i].stream_end, bytes_tbl[i].typed,
                bytes_tbl[i].res);
    drain();

    // Receiver holds off while the sender keeps offering bytes
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_cnt = HoldCycles;
    sent = 0;
    while (sent < 24) send_random_run(sent);
    drain();

    // Random runs under each idling mix
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_tbl[p];
      sink_stall_pct = sink_tbl[p];
      sent = 0;
      while (sent < PhaseItems) send_random_run(sent);
      drain();
    end

    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_if.sv
rtl/core/utf8_stream_decoder_core.sv
dv/tb_utf8_stream_decoder_core.sv
